// ----- hw/rtl/tir_pkg.sv -----
// ----------------------------------------------------------------------------
// tir_pkg
// Shared constants, codes and controller/datapath link types for the tile
// index resolver.
// ----------------------------------------------------------------------------
package tir_pkg;

    localparam int DEF_MAX_ENTRIES = 1024;

    localparam int SET_CODE_W   = 16;
    localparam int TILE_INDEX_W = 10;
    localparam int LOCAL_W      = 8;
    localparam int OFFSET_W     = 6;
    localparam int ENTRY_W      = 2 * SET_CODE_W + 1;

    localparam int FIRST_SET_TILE = 90;
    localparam int SET_SPAN       = 36;
    localparam int LAST_SET_TILE  = FIRST_SET_TILE + 4 * SET_SPAN;

    localparam int CFG_INDEX_W = 3;

    // operation codes
    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_APPEND  = 2'd1;
    localparam logic [1:0] OP_RESOLVE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MAP_SET_0    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAP_SET_1    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAP_SET_2    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAP_SET_3    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INVALID_SET  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_VARIANT = 3'd5;

    typedef struct packed {
        logic accept;
        logic decode;
        logic scan;
        logic load_out;
    } tir_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic out_free;
    } tir_sts_t;

endpackage

// ----- hw/rtl/tir_ctrl.sv -----
// ----------------------------------------------------------------------------
// tir_ctrl
// Sequencer: takes an item, decodes it, runs the entry scan when a resolve
// needs one and hands the result to the output register.
// ----------------------------------------------------------------------------
module tir_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  tir_pkg::tir_sts_t sts,
    output tir_pkg::tir_cmd_t cmd
);
    import tir_pkg::*;

    typedef enum logic [1:0] {
        IDLE,
        DECODE,
        SCAN,
        FINISH
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                IDLE:
                begin
                    if (s_tvalid && ready_reg)
                    begin
                        state_reg <= DECODE;
                        ready_reg <= 1'b0;
                    end
                end
                DECODE:
                begin
                    state_reg <= sts.need_scan ? SCAN : FINISH;
                end
                SCAN:
                begin
                    if (sts.scan_done)
                    begin
                        state_reg <= FINISH;
                    end
                end
                FINISH:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign s_tready     = ready_reg;
    assign cmd.accept   = ready_reg && s_tvalid;
    assign cmd.decode   = (state_reg == DECODE);
    assign cmd.scan     = (state_reg == SCAN);
    assign cmd.load_out = (state_reg == FINISH) && sts.out_free;

endmodule

// ----- hw/rtl/tir_dp.sv -----
// ----------------------------------------------------------------------------
// tir_dp
// Datapath: configuration registers, item registers, entry store with one
// read port, linear base search and the output register.
// ----------------------------------------------------------------------------
module tir_dp
#(
    parameter int MAX_ENTRIES = tir_pkg::DEF_MAX_ENTRIES
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [tir_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tir_pkg::SET_CODE_W-1:0]  cfg_data,
    input  logic [47:0]                    s_tdata,
    input  logic [1:0]                     s_tuser,
    input  tir_pkg::tir_cmd_t              cmd,
    output tir_pkg::tir_sts_t              sts,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,
    output logic [1:0]                     m_tuser
);
    import tir_pkg::*;

    localparam int IDX_W    = $clog2(MAX_ENTRIES);
    localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
    localparam int IDXSUM_W = (CNT_W + 1 > TILE_INDEX_W) ? CNT_W + 1 : TILE_INDEX_W;

    // configuration
    logic [SET_CODE_W-1:0] map_set_reg [4];
    logic [SET_CODE_W-1:0] invalid_set_reg;
    logic [SET_CODE_W-1:0] base_variant_reg;

    // latched item
    logic [1:0]            op_reg;
    logic [SET_CODE_W-1:0] set_in_reg;
    logic [SET_CODE_W-1:0] var_in_reg;
    logic                  named_in_reg;
    logic [LOCAL_W-1:0]    local_reg;

    // table
    logic [ENTRY_W-1:0]    store_mem [MAX_ENTRIES];
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    // scan
    logic [CNT_W-1:0]      scan_idx_reg;
    logic [IDX_W-1:0]      chk_idx_reg;
    logic                  chk_valid_reg;
    logic [ENTRY_W-1:0]    rd_data_reg;

    // result and output
    logic [1:0]              res_status_reg;
    logic [TILE_INDEX_W-1:0] res_index_reg;
    logic [1:0]              res_status_next;
    logic [TILE_INDEX_W-1:0] res_index_next;
    logic                    out_valid_reg;
    logic [1:0]              out_status_reg;
    logic [TILE_INDEX_W-1:0] out_index_reg;

    logic [LOCAL_W-1:0]      tile_off;
    logic [1:0]              slot;
    logic [LOCAL_W-1:0]      slot_base;
    logic [OFFSET_W-1:0]     offset;
    logic [SET_CODE_W-1:0]   target_set;

    logic [1:0]              dec_status;
    logic [TILE_INDEX_W-1:0] dec_index;
    logic                    dec_scan;
    logic                    dec_write;

    logic                    scan_more;
    logic                    scan_issue;
    logic                    entry_match;
    logic                    scan_hit;
    logic                    scan_miss;
    logic [IDXSUM_W-1:0]     idx_sum;
    logic                    in_range;
    logic                    out_free;

    // slot and offset within the four map tileset bands
    assign tile_off = local_reg - LOCAL_W'(FIRST_SET_TILE);

    always_comb
    begin
        priority if (tile_off >= LOCAL_W'(3 * SET_SPAN))
        begin
            slot      = 2'd3;
            slot_base = LOCAL_W'(3 * SET_SPAN);
        end
        else if (tile_off >= LOCAL_W'(2 * SET_SPAN))
        begin
            slot      = 2'd2;
            slot_base = LOCAL_W'(2 * SET_SPAN);
        end
        else if (tile_off >= LOCAL_W'(SET_SPAN))
        begin
            slot      = 2'd1;
            slot_base = LOCAL_W'(SET_SPAN);
        end
        else
        begin
            slot      = 2'd0;
            slot_base = '0;
        end
    end

    assign offset     = OFFSET_W'(tile_off - slot_base);
    assign target_set = map_set_reg[slot];

    always_comb
    begin
        dec_status = ST_OK;
        dec_index  = '0;
        dec_scan   = 1'b0;
        dec_write  = 1'b0;
        count_next = count_reg;
        if (cmd.decode)
        begin
            unique case (op_reg)
                OP_CLEAR:
                begin
                    count_next = '0;
                end
                OP_APPEND:
                begin
                    if (count_reg == CNT_W'(MAX_ENTRIES))
                    begin
                        dec_status = ST_FULL;
                    end
                    else
                    begin
                        dec_write  = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_RESOLVE:
                begin
                    priority if (count_reg == '0)
                    begin
                        dec_status = ST_NOT_FOUND;
                    end
                    else if (local_reg < LOCAL_W'(FIRST_SET_TILE))
                    begin
                        dec_index = TILE_INDEX_W'(local_reg);
                    end
                    else if (local_reg >= LOCAL_W'(LAST_SET_TILE))
                    begin
                        dec_status = ST_NOT_FOUND;
                    end
                    else if (target_set == invalid_set_reg)
                    begin
                        dec_status = ST_NOT_FOUND;
                    end
                    else
                    begin
                        dec_scan = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // one store read issued per cycle, compared in the cycle after
    assign scan_more   = (scan_idx_reg < count_reg);
    assign scan_issue  = cmd.scan && scan_more;
    assign entry_match = (rd_data_reg[ENTRY_W-1 -: SET_CODE_W] == target_set)
                      && (rd_data_reg[SET_CODE_W:1] == base_variant_reg)
                      && rd_data_reg[0];
    assign scan_hit    = cmd.scan && chk_valid_reg && entry_match;
    assign scan_miss   = cmd.scan && !chk_valid_reg && !scan_more;
    assign idx_sum     = IDXSUM_W'(chk_idx_reg) + IDXSUM_W'(offset);
    assign in_range    = (idx_sum < IDXSUM_W'(count_reg));

    always_comb
    begin
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        priority if (cmd.decode)
        begin
            res_status_next = dec_status;
            res_index_next  = dec_index;
        end
        else if (scan_hit)
        begin
            res_status_next = in_range ? ST_OK : ST_NOT_FOUND;
            res_index_next  = in_range ? idx_sum[TILE_INDEX_W-1:0] : '0;
        end
        else if (scan_miss)
        begin
            res_status_next = ST_NOT_FOUND;
            res_index_next  = '0;
        end
        else
        begin
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                map_set_reg[i] <= '1;
            end
            invalid_set_reg  <= '1;
            base_variant_reg <= '0;
            count_reg        <= '0;
            scan_idx_reg     <= '0;
            chk_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_MAP_SET_0:    map_set_reg[0]   <= cfg_data;
                    REG_MAP_SET_1:    map_set_reg[1]   <= cfg_data;
                    REG_MAP_SET_2:    map_set_reg[2]   <= cfg_data;
                    REG_MAP_SET_3:    map_set_reg[3]   <= cfg_data;
                    REG_INVALID_SET:  invalid_set_reg  <= cfg_data;
                    REG_BASE_VARIANT: base_variant_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            count_reg <= count_next;
            if (cmd.decode)
            begin
                scan_idx_reg  <= '0;
                chk_valid_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                chk_valid_reg <= scan_issue;
                if (scan_issue)
                begin
                    scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg       <= s_tuser;
            set_in_reg   <= s_tdata[15:0];
            var_in_reg   <= s_tdata[31:16];
            named_in_reg <= s_tdata[32];
            local_reg    <= s_tdata[40:33];
        end
        if (scan_issue)
        begin
            chk_idx_reg <= scan_idx_reg[IDX_W-1:0];
        end
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
        end
    end

    // entry store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (dec_write)
        begin
            store_mem[count_reg[IDX_W-1:0]] <= {set_in_reg, var_in_reg, named_in_reg};
        end
        if (scan_issue)
        begin
            rd_data_reg <= store_mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

    assign sts.need_scan = dec_scan;
    assign sts.scan_done = scan_hit || scan_miss;
    assign sts.out_free  = out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(16 - TILE_INDEX_W){1'b0}}, out_index_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count past table size");

    a_fail_no_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != ST_OK) |-> (out_index_reg == '0))
        else $error("failed item carries a tile index");

    a_hit_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        scan_hit |-> (CNT_W'(chk_idx_reg) < count_reg))
        else $error("base entry found beyond entry count");

endmodule

// ----- hw/rtl/tile_id_resolver.sv -----
// ----------------------------------------------------------------------------
// tile_id_resolver
// Tile entry table with clear, append and local-to-global tile resolve.
// ----------------------------------------------------------------------------
// One result item per input item. An item is taken only while the block is
// idle, but a finished result may still sit in the output register while the
// next item is taken. Clear, append, unused operations and resolves that end
// without a search pass from acceptance through the decode and finish states
// to the output register. A resolve of a map tileset byte searches the entry
// store linearly from entry 0 through its single read port, one entry a cycle,
// pipelined one deep, and stops at the first matching entry, or at the entry
// count when no entry matches. The entry store is not cleared after reset;
// entries are only read below the entry count.
module tile_id_resolver
#(
    parameter int MAX_ENTRIES = tir_pkg::DEF_MAX_ENTRIES
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [tir_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tir_pkg::SET_CODE_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [47:0]                     s_tdata,  // entry_set, entry_variant,
                                                      // entry_named, local_tile
    input  logic [1:0]                      s_tuser,  // operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,  // tile_index
    output logic [1:0]                      m_tuser   // status
);
    import tir_pkg::*;

    tir_cmd_t cmd;
    tir_sts_t sts;

    tir_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tir_dp
    #(
        .MAX_ENTRIES (MAX_ENTRIES)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- dv/tir_checker.sv -----
// ----------------------------------------------------------------------------
// tir_checker
// Watches the register port and both item channels of the tile index
// resolver, keeps its own copy of the entry table and the map registers,
// works out the answer to every accepted item and compares it, in order,
// with the results the block hands out.
// ----------------------------------------------------------------------------
module tir_checker
#(
    parameter int MAX_ENTRIES = tir_pkg::DEF_MAX_ENTRIES
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [tir_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tir_pkg::SET_CODE_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [47:0]                     s_tdata,   // entry_set, entry_variant,
                                                       // entry_named, local_tile
    input  logic [1:0]                      s_tuser,   // operation
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [15:0]                     m_tdata,   // tile_index
    input  logic [1:0]                      m_tuser,   // status
    output int                              failures,
    output int                              results,
    output int                              waiting
);
    import tir_pkg::*;

    typedef struct packed {
        logic [1:0]              status;
        logic [TILE_INDEX_W-1:0] index;
    } tile_answer_t;

    logic [SET_CODE_W-1:0] slot_code [4];
    logic [SET_CODE_W-1:0] unused_code;
    logic [SET_CODE_W-1:0] base_variant;

    logic [SET_CODE_W-1:0] tbl_set     [MAX_ENTRIES];
    logic [SET_CODE_W-1:0] tbl_variant [MAX_ENTRIES];
    logic                  tbl_named   [MAX_ENTRIES];
    int                    fill;

    tile_answer_t answer_q [$];

    // applies one item to the table copy and returns the answer it earns
    function automatic tile_answer_t apply_item(input logic [1:0] op, input logic [47:0] data);
        tile_answer_t          a;
        logic [7:0]            tile;
        logic [SET_CODE_W-1:0] code;
        int                    slot;
        int                    offset;
        int                    base;
        bit                    found;
        a.status = ST_OK;
        a.index  = '0;
        tile     = data[40:33];
        case (op)
            OP_CLEAR:
                fill = 0;
            OP_APPEND:
                if (fill >= MAX_ENTRIES)
                    a.status = ST_FULL;
                else
                begin
                    tbl_set[fill]     = data[15:0];
                    tbl_variant[fill] = data[31:16];
                    tbl_named[fill]   = data[32];
                    fill++;
                end
            OP_RESOLVE:
                if (fill == 0)
                    a.status = ST_NOT_FOUND;
                else if (tile < FIRST_SET_TILE)
                    a.index = TILE_INDEX_W'(tile);
                else if (tile >= LAST_SET_TILE)
                    a.status = ST_NOT_FOUND;
                else
                begin
                    slot   = (int'(tile) - FIRST_SET_TILE) / SET_SPAN;
                    offset = (int'(tile) - FIRST_SET_TILE) % SET_SPAN;
                    code   = slot_code[slot];
                    found  = 1'b0;
                    base   = 0;
                    if (code != unused_code)
                        for (int i = 0; i < fill && !found; i++)
                            if (tbl_set[i] == code && tbl_variant[i] == base_variant &&
                                tbl_named[i])
                            begin
                                found = 1'b1;
                                base  = i;
                            end
                    if (!found || base + offset >= fill)
                        a.status = ST_NOT_FOUND;
                    else
                        a.index = TILE_INDEX_W'(base + offset);
                end
            default:
                ;
        endcase
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        tile_answer_t due;
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
                slot_code[k] = 16'hFFFF;
            unused_code  = 16'hFFFF;
            base_variant = '0;
            fill         = 0;
            answer_q.delete();
            failures     = 0;
            results      = 0;
            waiting      = 0;
        end
        else
        begin
            if (cfg_wr_en)
                case (cfg_index)
                    REG_MAP_SET_0:    slot_code[0] = cfg_data;
                    REG_MAP_SET_1:    slot_code[1] = cfg_data;
                    REG_MAP_SET_2:    slot_code[2] = cfg_data;
                    REG_MAP_SET_3:    slot_code[3] = cfg_data;
                    REG_INVALID_SET:  unused_code  = cfg_data;
                    REG_BASE_VARIANT: base_variant = cfg_data;
                    default:          ;
                endcase

            if (s_tvalid && s_tready)
                answer_q.insert(answer_q.size(), apply_item(s_tuser, s_tdata));

            if (m_tvalid && m_tready)
            begin
                results++;
                if (answer_q.size() == 0)
                begin
                    failures++;
                    $error("unexpected result: status %0d tile_index %0d", m_tuser, m_tdata);
                end
                else
                begin
                    due = answer_q.pop_front();
                    if (m_tuser !== due.status)
                    begin
                        failures++;
                        $error("status: expected %0d, actual %0d", due.status, m_tuser);
                    end
                    if (m_tdata !== {6'b0, due.index})
                    begin
                        failures++;
                        $error("tile_index: expected %0d, actual %0d", due.index, m_tdata);
                    end
                end
            end
            waiting = answer_q.size();
        end
    end

endmodule

// ----- dv/tb_tile_id_resolver.sv -----
// ----------------------------------------------------------------------------
// tb_tile_id_resolver
// Drives the tile index resolver with directed items (empty table, pass-
// through, high bytes, unused slot, offset past the end, skipped entries),
// then random phases under changing map settings. Both channels idle at
// random; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_tile_id_resolver;
    import tir_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [SET_CODE_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic [47:0]            s_tdata   = '0;
    logic [1:0]             s_tuser   = '0;
    logic                   m_tready  = 1'b0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [15:0]            m_tdata;
    logic [1:0]             m_tuser;

    int chk_fails;
    int chk_results;
    int chk_waiting;
    int items_sent = 0;
    bit steady     = 1'b0;
    bit hold_out   = 1'b0;

    logic [SET_CODE_W-1:0] code_pool [4];
    logic [SET_CODE_W-1:0] base_var;

    always #10 clk = ~clk;

    tile_id_resolver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    tir_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .failures  (chk_fails),
        .results   (chk_results),
        .waiting   (chk_waiting)
    );

    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random back-pressure, or one long hold when asked
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_out)
            begin
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_out = 1'b0;
                m_tready <= 1'b1;
            end
            else
                m_tready <= steady || ($urandom_range(99) >= 20);
        end
    end

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [15:0] set_code,
                             input logic [15:0] variant, input logic named,
                             input logic [7:0] tile);
        if (!steady && $urandom_range(99) < 20)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'b0, tile, named, variant, set_code};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    task automatic append(input logic [15:0] set_code, input logic [15:0] variant,
                          input logic named);
        send_item(OP_APPEND, set_code, variant, named, 8'($urandom));
    endtask

    task automatic resolve(input logic [7:0] tile);
        send_item(OP_RESOLVE, rnd16(), rnd16(), 1'($urandom), tile);
    endtask

    task automatic clear_table();
        send_item(OP_CLEAR, rnd16(), rnd16(), 1'($urandom), 8'($urandom));
    endtask

    // let every result come back so the block is idle
    task automatic settle();
        s_tvalid <= 1'b0;
        wait (chk_results == items_sent);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic program_map(input logic [15:0] m0, input logic [15:0] m1,
                               input logic [15:0] m2, input logic [15:0] m3,
                               input logic [15:0] inv, input logic [15:0] bv);
        write_reg(REG_MAP_SET_0, m0);
        write_reg(REG_MAP_SET_1, m1);
        write_reg(REG_MAP_SET_2, m2);
        write_reg(REG_MAP_SET_3, m3);
        write_reg(REG_INVALID_SET, inv);
        write_reg(REG_BASE_VARIANT, bv);
        cfg_wr_en <= 1'b0;
        base_var = bv;
    endtask

    // mostly map-tileset bytes, often with small offsets
    function automatic logic [7:0] pick_tile();
        int r;
        int slot;
        int off;
        r = $urandom_range(99);
        if (r < 15)
            return 8'($urandom_range(0, FIRST_SET_TILE - 1));
        if (r < 25)
            return 8'($urandom_range(LAST_SET_TILE, 255));
        slot = $urandom_range(0, 3);
        off  = (r < 60) ? $urandom_range(0, 5) : $urandom_range(0, SET_SPAN - 1);
        return 8'(FIRST_SET_TILE + slot * SET_SPAN + off);
    endfunction

    task automatic random_phase(input int n_items);
        int roll;
        clear_table();
        for (int n = 0; n < n_items; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 3)
                clear_table();
            else if (roll < 6)
                send_item(OP_UNUSED, rnd16(), rnd16(), 1'($urandom), 8'($urandom));
            else if (roll < 12)
                send_item($urandom_range(1) ? OP_APPEND : OP_RESOLVE, rnd16(), rnd16(),
                          1'($urandom), 8'($urandom));
            else if (roll < 50)
                append(($urandom_range(99) < 80) ? code_pool[$urandom_range(0, 3)] : rnd16(),
                       ($urandom_range(99) < 70) ? base_var : rnd16(),
                       $urandom_range(99) < 85);
            else
                resolve(pick_tile());
        end
    endtask

    initial
    begin
        logic [15:0] inv;
        base_var = '0;
        for (int k = 0; k < 4; k++)
            code_pool[k] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: every slot holds the unused code
        resolve(8'd100);
        resolve(8'd0);
        send_item(OP_UNUSED, rnd16(), rnd16(), 1'($urandom), 8'($urandom));
        append(16'hFFFF, 16'h0000, 1'b1);
        resolve(8'd90);
        resolve(8'd0);
        resolve(8'd89);
        resolve(8'd255);

        settle();
        program_map(16'd10, 16'd20, 16'd30, 16'hFFFF, 16'hFFFF, 16'd7);
        clear_table();
        append(16'd10, 16'd7, 1'b0);
        append(16'd10, 16'd3, 1'b1);
        append(16'd10, 16'd7, 1'b1);
        append(16'd20, 16'd7, 1'b1);
        append(16'd30, 16'd7, 1'b1);
        append(16'd20, 16'd7, 1'b1);
        resolve(8'd90);
        resolve(8'd92);
        resolve(8'd93);
        resolve(8'd94);
        resolve(8'd126);
        resolve(8'd162);
        resolve(8'd198);
        resolve(8'd233);
        resolve(8'd234);
        send_item(OP_UNUSED, rnd16(), rnd16(), 1'($urandom), 8'($urandom));

        for (int p = 0; p < 9; p++)
        begin
            settle();
            for (int k = 0; k < 4; k++)
                code_pool[k] = rnd16();
            if (p == 0)
                code_pool[0] = 16'h0000;
            if (p == 1)
                code_pool[1] = 16'hFFFF;
            case (p)
                0:       inv = 16'hFFFF;
                1:       inv = 16'h0000;
                2:       inv = code_pool[3];
                default: inv = rnd16();
            endcase
            program_map(code_pool[0], code_pool[1], code_pool[2],
                        (p % 3 == 0) ? inv : code_pool[3], inv,
                        (p == 0) ? 16'h0000 : ((p == 1) ? 16'hFFFF : rnd16()));
            steady   = (p == 4);
            hold_out = (p == 6);
            random_phase(60);
        end
        steady = 1'b0;

        settle();
        repeat (40) @(posedge clk);
        if (chk_fails == 0 && chk_waiting == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- tile_id_resolver.f -----
hw/rtl/tir_pkg.sv
hw/rtl/tir_ctrl.sv
hw/rtl/tir_dp.sv
hw/rtl/tile_id_resolver.sv
dv/tir_checker.sv
dv/tb_tile_id_resolver.sv
